>>> rtl/phs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_pkg
// Shared sizes, command codes and word formats of the packet header stack.
// ----------------------------------------------------------------------------
package phs_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;

   localparam int CMD_W   = 3;
   localparam int SHIFT_W = 5;
   localparam int ENTRY_W = 6;
   localparam int WDATA_W = 32;
   localparam int COUNT_W = 5;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = CNT_W + ENTRY_W + 1;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_POP_FRONT  = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_WRITE      = 3'd4,
      CMD_READ       = 3'd5,
      CMD_CLEAR      = 3'd6,
      CMD_NOP        = 3'd7
   } phs_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [SHIFT_W-1:0] shift_amount;
      logic [ENTRY_W-1:0] entry_index;
      logic [WDATA_W-1:0] write_data;
      logic               write_valid;
   } phs_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] moved_count;
      logic [WDATA_W-1:0] read_data;
      logic               read_valid;
      logic [COUNT_W-1:0] entry_count;
      logic               stack_full;
      logic               index_error;
   } phs_rsp_type;

   typedef logic [DEPTH-1:0][DATA_WIDTH-1:0] phs_data_array_type;

   // bit n is set when n divides |d| with a quotient of at most DEPTH, for n in 1..DEPTH
   function automatic logic [DEPTH:0] div_mask(input int d);
      logic [DEPTH:0] m;
      int             a;
      m = '0;
      a = (d < 0) ? -d : d;
      for (int n = 1; n <= DEPTH; n++) begin
         for (int k = 0; k <= DEPTH; k++) begin
            if (k * n == a) begin
               m[n] = 1'b1;
            end
         end
      end
      return m;
   endfunction

endpackage

>>> rtl/phs_front_shift.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_front_shift
// Front push and pop network: moves entries by the shift amount and marks
// pushed or vacated entries, for both legacy and whole-array rules.
// ----------------------------------------------------------------------------
module phs_front_shift (
   input  logic                         shift_mode,
   input  logic                         is_pop,
   input  logic [phs_pkg::SHIFT_W-1:0]  shift_amount,
   input  logic [phs_pkg::CNT_W-1:0]    fill,
   input  phs_pkg::phs_data_array_type  data_cur,
   input  logic [phs_pkg::DEPTH-1:0]    valid_cur,
   output phs_pkg::phs_data_array_type  data_new,
   output logic [phs_pkg::DEPTH-1:0]    valid_new,
   output logic [phs_pkg::CNT_W-1:0]    fill_new,
   output logic [phs_pkg::CNT_W-1:0]    moved
);
   import phs_pkg::*;

   localparam int XW = CNT_W + 1;

   logic [CNT_W-1:0]            n;
   logic [XW-1:0]               sum;
   logic [CNT_W-1:0]            push_fill;
   logic [CNT_W-1:0]            popped;
   logic [CNT_W-1:0]            pop_fill;
   logic [CNT_W-1:0]            bound;
   logic [CNT_W-1:0]            upper;
   logic [XW-1:0]               nx;
   logic [XW-1:0]               bx;
   logic [XW-1:0]               ux;
   logic [DEPTH-1:0][DEPTH-1:0] hit;

   always_comb begin
      if (CMP_W'(shift_amount) > CMP_W'(DEPTH)) begin
         n = CNT_W'(DEPTH);
      end else begin
         n = CNT_W'(shift_amount);
      end
      sum       = XW'(fill) + XW'(n);
      push_fill = (sum > XW'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(sum);
      popped    = (fill < n) ? fill : n;
      pop_fill  = fill - popped;
      if (is_pop) begin
         bound = shift_mode ? (CNT_W'(DEPTH) - n) : pop_fill;
      end else begin
         bound = shift_mode ? CNT_W'(DEPTH) : push_fill;
      end
      upper    = shift_mode ? CNT_W'(DEPTH) : fill;
      fill_new = is_pop ? pop_fill : push_fill;
      moved    = (is_pop && !shift_mode) ? popped : n;
      nx       = XW'(n);
      bx       = XW'(bound);
      ux       = XW'(upper);
   end

   for (genvar j = 0; j < DEPTH; j++) begin : g_dst
      for (genvar i = 0; i < DEPTH; i++) begin : g_src
         localparam logic [DEPTH:0] DIV = div_mask(i - j);
         logic push_hit;
         logic pop_hit;
         assign push_hit =
            ((XW'(j) >= nx) && (XW'(j) < bx) && ((XW'(i) + nx) == XW'(j))) ||
            ((XW'(j) < nx) && DIV[n] && ((XW'(i) + nx) >= bx) && (XW'(i) < bx));
         assign pop_hit =
            ((XW'(j) < bx) && (XW'(i) == (XW'(j) + nx))) ||
            ((XW'(j) >= bx) && (XW'(j) < (bx + nx)) && (XW'(j) >= nx) &&
             (XW'(i) < nx) && DIV[n]);
         assign hit[j][i] = is_pop ? pop_hit : push_hit;
      end
   end

   always_comb begin
      for (int j = 0; j < DEPTH; j++) begin
         data_new[j]  = data_cur[j];
         valid_new[j] = valid_cur[j];
         for (int i = 0; i < DEPTH; i++) begin
            if (hit[j][i]) begin
               data_new[j]  = data_cur[i];
               valid_new[j] = valid_cur[i];
            end
         end
         if (!is_pop && (XW'(j) < nx)) begin
            valid_new[j] = !shift_mode;
         end
         if (is_pop && (XW'(j) >= bx) && (XW'(j) < ux)) begin
            valid_new[j] = 1'b0;
         end
      end
   end

endmodule

>>> rtl/phs_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phs_stack
// Entry storage, fill count and mode register; decodes one command word
// and forms its result from the current state.
// ----------------------------------------------------------------------------
module phs_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  advance,
   input  phs_pkg::phs_req_type  cur_word,
   output phs_pkg::phs_rsp_type  result
);
   import phs_pkg::*;

   phs_data_array_type data_ff;
   phs_data_array_type data_in;
   logic [DEPTH-1:0]   valid_ff;
   logic [DEPTH-1:0]   valid_in;
   logic [CNT_W-1:0]   fill_ff;
   logic [CNT_W-1:0]   fill_in;
   logic               shift_mode_ff;

   phs_data_array_type sh_data;
   logic [DEPTH-1:0]   sh_valid;
   logic [CNT_W-1:0]   sh_fill;
   logic [CNT_W-1:0]   sh_moved;

   phs_cmd_type        cmd;
   logic               idx_ok;
   logic [IDX_W-1:0]   idx;
   logic [IDX_W-1:0]   fill_idx;
   logic [IDX_W-1:0]   last_idx;
   logic [CNT_W-1:0]   moved;

   phs_front_shift u_front_shift (
      .shift_mode   (shift_mode_ff),
      .is_pop       (cmd == CMD_POP_FRONT),
      .shift_amount (cur_word.shift_amount),
      .fill         (fill_ff),
      .data_cur     (data_ff),
      .valid_cur    (valid_ff),
      .data_new     (sh_data),
      .valid_new    (sh_valid),
      .fill_new     (sh_fill),
      .moved        (sh_moved)
   );

   always_comb begin
      cmd      = phs_cmd_type'(cur_word.cmd);
      idx_ok   = CMP_W'(cur_word.entry_index) < CMP_W'(DEPTH);
      idx      = cur_word.entry_index[IDX_W-1:0];
      fill_idx = fill_ff[IDX_W-1:0];
      last_idx = fill_idx - 1'b1;

      data_in  = data_ff;
      valid_in = valid_ff;
      fill_in  = fill_ff;
      moved    = '0;
      result   = '0;

      case (cmd)
         CMD_PUSH_FRONT, CMD_POP_FRONT: begin
            data_in  = sh_data;
            valid_in = sh_valid;
            fill_in  = sh_fill;
            moved    = sh_moved;
         end
         CMD_PUSH_BACK: begin
            if (fill_ff < CNT_W'(DEPTH)) begin
               valid_in[fill_idx] = 1'b1;
               fill_in            = fill_ff + 1'b1;
               moved              = CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (fill_ff != '0) begin
               valid_in[last_idx] = 1'b0;
               fill_in            = fill_ff - 1'b1;
               moved              = CNT_W'(1);
            end
         end
         CMD_WRITE: begin
            if (idx_ok) begin
               data_in[idx]  = DATA_WIDTH'(cur_word.write_data);
               valid_in[idx] = cur_word.write_valid;
            end else begin
               result.index_error = 1'b1;
            end
         end
         CMD_READ: begin
            if (idx_ok) begin
               result.read_data  = WDATA_W'(data_ff[idx]);
               result.read_valid = valid_ff[idx];
            end else begin
               result.index_error = 1'b1;
            end
         end
         CMD_CLEAR: begin
            fill_in = '0;
         end
         default: begin
         end
      endcase

      result.moved_count = COUNT_W'(moved);
      result.entry_count = COUNT_W'(fill_in);
      result.stack_full  = fill_in >= CNT_W'(DEPTH);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         fill_ff       <= '0;
         shift_mode_ff <= 1'b1;
      end else begin
         if (advance) begin
            valid_ff <= valid_in;
            fill_ff  <= fill_in;
         end
         if (csr_wr_en) begin
            shift_mode_ff <= csr_wr_data;
         end
      end
   end

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(DEPTH))
      else $error("fill count above depth");

   a_push_back_count: assert property (@(posedge clock) disable iff (reset)
      (advance && (cmd == CMD_PUSH_BACK) && (fill_ff < CNT_W'(DEPTH)))
      |=> (fill_ff == CNT_W'($past(fill_ff) + 1'b1)))
      else $error("back push did not grow the count");

   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      (advance && (cmd == CMD_CLEAR)) |=> (fill_ff == '0))
      else $error("clear left a nonzero count");

endmodule

>>> rtl/packet_header_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_stack
// Fixed-depth header stack with front shifts, back push and pop, entry
// access and a fill count; one command word in, one result word out.
// ----------------------------------------------------------------------------
// A command word is captured in an input register, executed in a single
// pass through the front-shift network and command decode, and its result
// lands in an output register: the command waits in the input register
// while the output register holds an unaccepted result, and a new command
// word is taken every cycle as long as rsp_ready keeps up. The shift
// network between the two registers sets the clock rate. Write the
// shift_mode register only while no command is in flight.
// ----------------------------------------------------------------------------
module packet_header_stack (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  phs_pkg::phs_req_type  req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output phs_pkg::phs_rsp_type  rsp_word,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data
);
   import phs_pkg::*;

   logic        in_valid_ff;
   phs_req_type in_word_ff;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   phs_rsp_type rsp_word_ff;
   phs_rsp_type result;
   logic        advance;

   phs_stack u_stack (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .advance     (advance),
      .cur_word    (in_word_ff),
      .result      (result)
   );

   always_comb begin
      advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
      req_ready = !in_valid_ff || advance;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !advance)
      else $error("command executed while result stalled");

   a_capture: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> in_valid_ff)
      else $error("accepted word lost");

   a_error_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_word_ff.index_error)
      |-> ((rsp_word_ff.moved_count == '0) && !rsp_word_ff.read_valid &&
           (rsp_word_ff.read_data == '0)))
      else $error("index error with data or movement");

endmodule

>>> test/packet_header_stack_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_header_stack_test
// Self-checking bench for the packet header stack. Command words are driven
// through directed corner cases and weighted random sequences in both shift
// modes. Each accepted word is run through a local model of the stack, and
// every result word is compared against the oldest prediction. Both channels
// stall at random, but for one random sequence run with no idle cycles.
// ----------------------------------------------------------------------------
module packet_header_stack_test;
   import phs_pkg::*;

   localparam int QUIET_LIMIT = 2000;

   typedef struct {
      phs_rsp_type word;
      bit          data_known;
   } stack_result_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   phs_req_type req_word    = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   phs_rsp_type rsp_word;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;

   logic [DATA_WIDTH-1:0] held_data [DEPTH];
   bit                    held_valid [DEPTH];
   bit                    held_written [DEPTH];
   int unsigned           fill_level = 0;
   bit                    p4_rules   = 1'b1;

   stack_result_type results_due[$];

   bit send_idle       = 1'b1;
   bit recv_idle       = 1'b1;
   int fail_count      = 0;
   int words_sent      = 0;
   int results_checked = 0;
   int quiet_cycles    = 0;

   packet_header_stack i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic void swap_entries(input int unsigned a, input int unsigned b);
      logic [DATA_WIDTH-1:0] d;
      bit                    v;
      bit                    w;
      if (a >= DEPTH || b >= DEPTH) return;
      d = held_data[a];    held_data[a]    = held_data[b];    held_data[b]    = d;
      v = held_valid[a];   held_valid[a]   = held_valid[b];   held_valid[b]   = v;
      w = held_written[a]; held_written[a] = held_written[b]; held_written[b] = w;
   endfunction

   function automatic void predict_stack_step(input phs_req_type w);
      stack_result_type r;
      int unsigned      n;
      int unsigned      top;
      int unsigned      popped;
      r.word       = '0;
      r.data_known = 1'b1;
      n = (w.shift_amount > DEPTH) ? DEPTH : w.shift_amount;
      case (w.cmd)
         CMD_PUSH_FRONT: begin
            if (n != 0) begin
               top = (fill_level + n > DEPTH) ? DEPTH : fill_level + n;
               fill_level = top;
               if (p4_rules) top = DEPTH;
               for (int i = top; i > n; i--) swap_entries(i - 1, i - 1 - n);
               for (int i = 0; i < n; i++) begin
                  held_valid[i] = !p4_rules;
               end
               r.word.moved_count = COUNT_W'(n);
            end
         end
         CMD_POP_FRONT: begin
            if (n != 0) begin
               popped = (fill_level < n) ? fill_level : n;
               fill_level -= popped;
               if (p4_rules) begin
                  for (int i = 0; i < DEPTH - n; i++) swap_entries(i, i + n);
                  for (int i = DEPTH - n; i < DEPTH; i++) begin
                     held_valid[i] = 1'b0;
                  end
                  r.word.moved_count = COUNT_W'(n);
               end else begin
                  for (int i = 0; i < fill_level; i++) swap_entries(i, i + n);
                  for (int i = fill_level; i < fill_level + popped && i < DEPTH; i++) begin
                     held_valid[i] = 1'b0;
                  end
                  r.word.moved_count = COUNT_W'(popped);
               end
            end
         end
         CMD_PUSH_BACK: begin
            if (fill_level < DEPTH) begin
               held_valid[fill_level] = 1'b1;
               fill_level++;
               r.word.moved_count = COUNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (fill_level > 0) begin
               fill_level--;
               held_valid[fill_level] = 1'b0;
               r.word.moved_count = COUNT_W'(1);
            end
         end
         CMD_WRITE: begin
            if (w.entry_index < DEPTH) begin
               held_data[w.entry_index]    = w.write_data;
               held_valid[w.entry_index]   = w.write_valid;
               held_written[w.entry_index] = 1'b1;
            end else begin
               r.word.index_error = 1'b1;
            end
         end
         CMD_READ: begin
            if (w.entry_index < DEPTH) begin
               r.word.read_data  = held_data[w.entry_index];
               r.word.read_valid = held_valid[w.entry_index];
               r.data_known      = held_written[w.entry_index];
            end else begin
               r.word.index_error = 1'b1;
            end
         end
         CMD_CLEAR: fill_level = 0;
         default: ;
      endcase
      r.word.entry_count = COUNT_W'(fill_level);
      r.word.stack_full  = (fill_level >= DEPTH);
      results_due = {results_due, r};
   endfunction

   // pick a stored entry, or now and then an index past the end
   function automatic logic [ENTRY_W-1:0] pick_read_index();
      int unsigned stored[$];
      for (int i = 0; i < DEPTH; i++) begin
         if (held_written[i]) stored = {stored, i};
      end
      if (stored.size() == 0 || $urandom_range(99) < 12) begin
         return ENTRY_W'(DEPTH + $urandom_range(63 - DEPTH));
      end
      return ENTRY_W'(stored[$urandom_range(stored.size() - 1)]);
   endfunction

   function automatic phs_req_type random_word(input phs_cmd_type c);
      phs_req_type w;
      w.cmd          = c;
      w.shift_amount = SHIFT_W'(($urandom_range(99) < 75) ? $urandom_range(4, 1)
                                                          : $urandom_range(31));
      w.entry_index  = ENTRY_W'($urandom_range(63));
      w.write_data   = $urandom();
      w.write_valid  = 1'($urandom_range(1));
      if (c == CMD_READ) begin
         w.entry_index = pick_read_index();
      end else if (c == CMD_WRITE && $urandom_range(99) < 90) begin
         w.entry_index = ENTRY_W'($urandom_range(DEPTH - 1));
      end
      return w;
   endfunction

   task automatic send_word(input phs_req_type w);
      while (send_idle && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      predict_stack_step(w);
      words_sent++;
   endtask

   task automatic send_cmd(input phs_cmd_type c, input int unsigned shift,
                           input int unsigned index, input logic [31:0] data,
                           input bit valid);
      phs_req_type w;
      w.cmd          = c;
      w.shift_amount = SHIFT_W'(shift);
      w.entry_index  = ENTRY_W'(index);
      w.write_data   = data;
      w.write_valid  = valid;
      send_word(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(input bit p4);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= p4;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      p4_rules = p4;
   endtask

   task automatic test_p4_edges();
      send_cmd(CMD_WRITE, 0, 0, 32'hFFFF_FFFF, 1'b1);
      send_cmd(CMD_WRITE, 31, 15, 32'h0000_0000, 1'b0);
      send_cmd(CMD_WRITE, 0, 63, 32'hA5A5_5A5A, 1'b1);
      send_cmd(CMD_READ, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_READ, 0, 15, 32'h0, 1'b0);
      send_cmd(CMD_READ, 0, 16, 32'h0, 1'b0);
      send_cmd(CMD_PUSH_FRONT, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_PUSH_BACK, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_PUSH_FRONT, 31, 0, 32'h0, 1'b0);
      send_cmd(CMD_PUSH_BACK, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_FRONT, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_FRONT, 3, 0, 32'h0, 1'b0);
      send_word(random_word(CMD_READ));
      send_cmd(CMD_POP_FRONT, 31, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_BACK, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_CLEAR, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_NOP, 0, 0, 32'h0, 1'b0);
   endtask

   task automatic test_legacy_edges();
      set_mode(1'b0);
      send_cmd(CMD_WRITE, 0, 2, 32'h1234_5678, 1'b1);
      send_cmd(CMD_PUSH_FRONT, 3, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_FRONT, 2, 0, 32'h0, 1'b0);
      send_cmd(CMD_PUSH_FRONT, 31, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_BACK, 0, 0, 32'h0, 1'b0);
      send_cmd(CMD_POP_FRONT, 31, 0, 32'h0, 1'b0);
      send_word(random_word(CMD_READ));
   endtask

   task automatic test_random_mix(input bit p4, input int count, input bit idling);
      int          r;
      phs_cmd_type c;
      set_mode(p4);
      send_idle = idling;
      recv_idle = idling;
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(99);
         if (r < 20)      c = CMD_PUSH_BACK;
         else if (r < 32) c = CMD_POP_BACK;
         else if (r < 44) c = CMD_PUSH_FRONT;
         else if (r < 56) c = CMD_POP_FRONT;
         else if (r < 76) c = CMD_WRITE;
         else if (r < 94) c = CMD_READ;
         else if (r < 97) c = CMD_CLEAR;
         else             c = CMD_NOP;
         send_word(random_word(c));
         // hold the sender until the pipeline is empty
         if ($urandom_range(99) == 0) wait_drained();
      end
      send_idle = 1'b1;
      recv_idle = 1'b1;
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stack_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (results_due.size() == 0) begin
            $error("result word with no command pending");
            fail_count++;
         end else begin
            due = results_due[0];
            results_due.delete(0);
            check_field("moved_count", due.word.moved_count, rsp_word.moved_count);
            if (due.data_known) begin
               check_field("read_data", due.word.read_data, rsp_word.read_data);
            end
            check_field("read_valid", due.word.read_valid, rsp_word.read_valid);
            check_field("entry_count", due.word.entry_count, rsp_word.entry_count);
            check_field("stack_full", due.word.stack_full, rsp_word.stack_full);
            check_field("index_error", due.word.index_error, rsp_word.index_error);
            results_checked++;
         end
      end
      rsp_ready <= !recv_idle || ($urandom_range(99) >= 33);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_p4_edges();
      test_legacy_edges();
      test_random_mix(1'b1, 150, 1'b1);
      test_random_mix(1'b0, 150, 1'b1);
      test_random_mix(1'b1, 150, 1'b0);
      test_random_mix(1'b0, 200, 1'b1);
      wait_drained();
      repeat (8) @(posedge clock);
      $display("Sent %0d command words in both shift modes, %0d result words compared.",
               words_sent, results_checked);
      $display("Mismatches: %0d", fail_count);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
